FILE: design/jtl_pkg.sv
// Shared types, character codes and item helpers for the JSON token lexer.
package jtl_pkg;

  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_FLOAT = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_BOOL  = 3'd3;
  localparam logic [2:0] KIND_PUNCT = 3'd4;
  localparam logic [2:0] KIND_END   = 3'd5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNTERM   = 2'd1;
  localparam logic [1:0] ERR_ESCAPE   = 2'd2;
  localparam logic [1:0] ERR_UNEXPECT = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       token_first;
    logic       token_last;
    logic [1:0] error_code;
  } item_t;

  typedef struct packed {
    item_t item0;
    item_t item1;
    logic  two;
  } req_t;

  function automatic item_t mk_item(logic [2:0] kind, logic [7:0] data, logic has,
                                    logic first, logic tlast, logic [1:0] err);
    item_t it;
    it.kind        = kind;
    it.data_byte   = data;
    it.has_byte    = has;
    it.token_first = first;
    it.token_last  = tlast;
    it.error_code  = err;
    return it;
  endfunction

endpackage

FILE: design/jtl_if.sv
// Valid/ready channel interfaces for text bytes and token items.
interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source(output valid, output text_byte, input ready);
  modport sink(input valid, input text_byte, output ready);
endinterface

interface jtl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       token_first;
  logic       token_last;
  logic [1:0] error_code;
  logic       last;
  modport source(output valid, output kind, output data_byte, output has_byte,
                 output token_first, output token_last, output error_code,
                 output last, input ready);
  modport sink(input valid, input kind, input data_byte, input has_byte,
               input token_first, input token_last, input error_code,
               input last, output ready);
endinterface

FILE: design/jtl_front.sv
// Front end: accepts text bytes, runs the lexer mode machine, builds item requests.
module jtl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  jtl_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output jtl_pkg::req_t  req_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_INT,
    MODE_FRAC,
    MODE_KEY,
    MODE_ERR
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       quote_single_q, quote_single_d;
  logic       kw_false_q, kw_false_d;
  logic [2:0] kw_prog_q, kw_prog_d;

  logic [7:0]     c;
  logic           accept;
  logic           is_digit, is_alnum;
  jtl_pkg::item_t it0, it1, idle_item, end_item;
  logic [1:0]     cnt;
  logic           idle_emit;
  mode_e          idle_mode;
  logic           idle_qs, idle_kwf;
  logic [2:0]     idle_kwp;
  logic [2:0]     kw_len;
  logic [7:0]     kw_exp;
  logic [2:0]     num_kind;

  function automatic logic [7:0] kw_char(logic kwf, logic [2:0] p);
    logic [7:0] ch;
    if (kwf) begin
      case (p)
        3'd0:    ch = jtl_pkg::CH_F;
        3'd1:    ch = jtl_pkg::CH_LA;
        3'd2:    ch = jtl_pkg::CH_L;
        3'd3:    ch = jtl_pkg::CH_S;
        3'd4:    ch = jtl_pkg::CH_E;
        default: ch = jtl_pkg::CH_F;
      endcase
    end else begin
      case (p[1:0])
        2'd0:    ch = jtl_pkg::CH_T;
        2'd1:    ch = jtl_pkg::CH_R;
        2'd2:    ch = jtl_pkg::CH_U;
        2'd3:    ch = jtl_pkg::CH_E;
        default: ch = jtl_pkg::CH_T;
      endcase
    end
    return ch;
  endfunction

  assign c        = in_i.text_byte;
  assign in_i.ready = !full_i;
  assign accept   = in_i.valid && !full_i;
  assign is_digit = (c >= jtl_pkg::CH_0) && (c <= jtl_pkg::CH_9);
  assign is_alnum = is_digit || ((c >= jtl_pkg::CH_UA) && (c <= jtl_pkg::CH_UZ))
                    || ((c >= jtl_pkg::CH_LA) && (c <= jtl_pkg::CH_LZ));
  assign end_item = jtl_pkg::mk_item(jtl_pkg::KIND_END, 8'd0, 1'b0, 1'b1, 1'b1,
                                     jtl_pkg::ERR_NONE);
  assign kw_len   = kw_false_q ? 3'd5 : 3'd4;
  assign kw_exp   = kw_char(kw_false_q, kw_prog_q);
  assign num_kind = (mode_q == MODE_INT) ? jtl_pkg::KIND_INT : jtl_pkg::KIND_FLOAT;

  always_comb begin
    idle_emit = 1'b0;
    idle_item = '0;
    idle_mode = MODE_IDLE;
    idle_qs   = quote_single_q;
    idle_kwf  = kw_false_q;
    idle_kwp  = kw_prog_q;
    case (c)
      jtl_pkg::CH_NUL: begin
        idle_emit = 1'b1;
        idle_item = end_item;
      end
      jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_NL: begin
        idle_emit = 1'b0;
      end
      jtl_pkg::CH_LBRACE, jtl_pkg::CH_RBRACE, jtl_pkg::CH_LPAREN, jtl_pkg::CH_RPAREN,
      jtl_pkg::CH_COMMA, jtl_pkg::CH_LBRACK, jtl_pkg::CH_RBRACK, jtl_pkg::CH_COLON: begin
        idle_emit = 1'b1;
        idle_item = jtl_pkg::mk_item(jtl_pkg::KIND_PUNCT, c, 1'b1, 1'b1, 1'b1,
                                     jtl_pkg::ERR_NONE);
      end
      jtl_pkg::CH_DQUOTE, jtl_pkg::CH_SQUOTE: begin
        idle_emit = 1'b1;
        idle_qs   = (c == jtl_pkg::CH_SQUOTE);
        idle_item = jtl_pkg::mk_item(jtl_pkg::KIND_STR, 8'd0, 1'b0, 1'b1, 1'b0,
                                     jtl_pkg::ERR_NONE);
        idle_mode = MODE_STR;
      end
      jtl_pkg::CH_T, jtl_pkg::CH_F: begin
        idle_kwf  = (c == jtl_pkg::CH_F);
        idle_kwp  = 3'd1;
        idle_mode = MODE_KEY;
      end
      default: begin
        idle_emit = 1'b1;
        if (is_digit) begin
          idle_item = jtl_pkg::mk_item(jtl_pkg::KIND_INT, c, 1'b1, 1'b1, 1'b0,
                                       jtl_pkg::ERR_NONE);
          idle_mode = MODE_INT;
        end else begin
          idle_item = jtl_pkg::mk_item(jtl_pkg::KIND_PUNCT, c, 1'b0, 1'b1, 1'b1,
                                       jtl_pkg::ERR_UNEXPECT);
          idle_mode = MODE_ERR;
        end
      end
    endcase
  end

  always_comb begin
    it0            = '0;
    it1            = '0;
    cnt            = 2'd0;
    mode_d         = mode_q;
    quote_single_d = quote_single_q;
    kw_false_d     = kw_false_q;
    kw_prog_d      = kw_prog_q;
    case (mode_q)
      MODE_STR: begin
        if (c == (quote_single_q ? jtl_pkg::CH_SQUOTE : jtl_pkg::CH_DQUOTE)) begin
          it0    = jtl_pkg::mk_item(jtl_pkg::KIND_STR, 8'd0, 1'b0, 1'b0, 1'b1,
                                    jtl_pkg::ERR_NONE);
          cnt    = 2'd1;
          mode_d = MODE_IDLE;
        end else if (c == jtl_pkg::CH_NUL || c == jtl_pkg::CH_NL) begin
          it0 = jtl_pkg::mk_item(jtl_pkg::KIND_STR, c, 1'b0, 1'b0, 1'b1,
                                 jtl_pkg::ERR_UNTERM);
          it1 = end_item;
          cnt = (c == jtl_pkg::CH_NUL) ? 2'd2 : 2'd1;
          mode_d = (c == jtl_pkg::CH_NUL) ? MODE_IDLE : MODE_ERR;
        end else if (c == jtl_pkg::CH_BSLASH) begin
          mode_d = MODE_ESC;
        end else begin
          it0 = jtl_pkg::mk_item(jtl_pkg::KIND_STR, c, 1'b1, 1'b0, 1'b0,
                                 jtl_pkg::ERR_NONE);
          cnt = 2'd1;
        end
      end
      MODE_ESC: begin
        if (c == jtl_pkg::CH_N || c == jtl_pkg::CH_T || c == jtl_pkg::CH_DQUOTE ||
            c == jtl_pkg::CH_SQUOTE || c == jtl_pkg::CH_BSLASH) begin
          it0 = jtl_pkg::mk_item(jtl_pkg::KIND_STR,
                                 (c == jtl_pkg::CH_N) ? jtl_pkg::CH_NL :
                                 (c == jtl_pkg::CH_T) ? jtl_pkg::CH_TAB : c,
                                 1'b1, 1'b0, 1'b0, jtl_pkg::ERR_NONE);
          cnt    = 2'd1;
          mode_d = MODE_STR;
        end else begin
          it0 = jtl_pkg::mk_item(jtl_pkg::KIND_STR, c, 1'b0, 1'b0, 1'b1,
                                 jtl_pkg::ERR_ESCAPE);
          it1 = end_item;
          cnt = (c == jtl_pkg::CH_NUL) ? 2'd2 : 2'd1;
          mode_d = (c == jtl_pkg::CH_NUL) ? MODE_IDLE : MODE_ERR;
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (is_digit) begin
          it0 = jtl_pkg::mk_item(num_kind, c, 1'b1, 1'b0, 1'b0, jtl_pkg::ERR_NONE);
          cnt = 2'd1;
        end else if (c == jtl_pkg::CH_POINT && mode_q == MODE_INT) begin
          it0 = jtl_pkg::mk_item(jtl_pkg::KIND_FLOAT, c, 1'b1, 1'b0, 1'b0,
                                 jtl_pkg::ERR_NONE);
          cnt    = 2'd1;
          mode_d = MODE_FRAC;
        end else begin
          it0 = jtl_pkg::mk_item(num_kind, 8'd0, 1'b0, 1'b0, 1'b1, jtl_pkg::ERR_NONE);
          it1 = idle_item;
          cnt = idle_emit ? 2'd2 : 2'd1;
          mode_d         = idle_mode;
          quote_single_d = idle_qs;
          kw_false_d     = idle_kwf;
          kw_prog_d      = idle_kwp;
        end
      end
      MODE_KEY: begin
        if (kw_prog_q >= kw_len) begin
          if (is_alnum) begin
            it0 = jtl_pkg::mk_item(jtl_pkg::KIND_BOOL, c, 1'b0, 1'b1, 1'b1,
                                   jtl_pkg::ERR_UNEXPECT);
            cnt    = 2'd1;
            mode_d = MODE_ERR;
          end else begin
            it0 = jtl_pkg::mk_item(jtl_pkg::KIND_BOOL, {7'd0, !kw_false_q}, 1'b1,
                                   1'b1, 1'b1, jtl_pkg::ERR_NONE);
            it1 = idle_item;
            cnt = idle_emit ? 2'd2 : 2'd1;
            mode_d         = idle_mode;
            quote_single_d = idle_qs;
            kw_false_d     = idle_kwf;
            kw_prog_d      = idle_kwp;
          end
        end else if (c == kw_exp) begin
          kw_prog_d = kw_prog_q + 3'd1;
        end else begin
          it0 = jtl_pkg::mk_item(jtl_pkg::KIND_BOOL, c, 1'b0, 1'b1, 1'b1,
                                 jtl_pkg::ERR_UNEXPECT);
          it1 = end_item;
          cnt = (c == jtl_pkg::CH_NUL) ? 2'd2 : 2'd1;
          mode_d = (c == jtl_pkg::CH_NUL) ? MODE_IDLE : MODE_ERR;
        end
      end
      MODE_ERR: begin
        if (c == jtl_pkg::CH_NUL) begin
          it0    = end_item;
          cnt    = 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        it0 = idle_item;
        cnt = idle_emit ? 2'd1 : 2'd0;
        mode_d         = idle_mode;
        quote_single_d = idle_qs;
        kw_false_d     = idle_kwf;
        kw_prog_d      = idle_kwp;
      end
    endcase
  end

  assign push_o     = accept && (cnt != 2'd0);
  assign req_o.item0 = it0;
  assign req_o.item1 = it1;
  assign req_o.two   = cnt[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_IDLE;
      quote_single_q <= 1'b0;
      kw_false_q     <= 1'b0;
      kw_prog_q      <= 3'd0;
    end else if (accept) begin
      mode_q         <= mode_d;
      quote_single_q <= quote_single_d;
      kw_false_q     <= kw_false_d;
      kw_prog_q      <= kw_prog_d;
    end
  end

endmodule

FILE: design/jtl_queue.sv
// Two-entry request queue between the lexer front end and the output stage.
module jtl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jtl_pkg::req_t  req_i,
  input  logic           pop_i,
  output jtl_pkg::req_t  head_o,
  output logic           full_o,
  output logic           empty_o
);

  jtl_pkg::req_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: design/jtl_back.sv
// Output stage: delivers the one or two items of each queued request in order.
module jtl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  jtl_pkg::req_t  head_i,
  output logic           pop_o,
  jtl_out_if.source      out_o
);

  logic           idx_q;
  logic           is_last;
  jtl_pkg::item_t cur;

  assign cur     = idx_q ? head_i.item1 : head_i.item0;
  assign is_last = idx_q || !head_i.two;

  assign out_o.valid       = !empty_i;
  assign out_o.kind        = cur.kind;
  assign out_o.data_byte   = cur.data_byte;
  assign out_o.has_byte    = cur.has_byte;
  assign out_o.token_first = cur.token_first;
  assign out_o.token_last  = cur.token_last;
  assign out_o.error_code  = cur.error_code;
  assign out_o.last        = is_last;

  assign pop_o = !empty_i && out_o.ready && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else if (!empty_i && out_o.ready) begin
      idx_q <= !is_last;
    end
  end

endmodule

FILE: design/json_token_lexer_unit.sv
// Top level of the JSON token lexer: front end, request queue and output stage.
// A byte's item request is registered in the queue and offered from its head.
// Throughput: one byte per cycle while no byte yields two items and the output is
// not stalled; a two-item byte holds the single output port until both are taken.
// Reset (rst_ni low, asynchronous): lexer back to idle, queue emptied, no item offered.
module json_token_lexer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  jtl_in_if.sink     in_i,
  jtl_out_if.source  out_o
);

  logic          push, pop, full, empty;
  jtl_pkg::req_t req, head;

  jtl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .req_o  (req)
  );

  jtl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  jtl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

FILE: design/jtl_checker.sv
// Port-level assertions for the JSON token lexer and their bind to the top level.
module jtl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] kind_i,
  input logic [7:0] data_byte_i,
  input logic       has_byte_i,
  input logic       token_first_i,
  input logic       token_last_i,
  input logic [1:0] error_code_i,
  input logic       last_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output request dropped while stalled");

  a_error_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (error_code_i != jtl_pkg::ERR_NONE) |-> token_last_i && !has_byte_i)
    else $error("error item does not close its token");

  a_end_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == jtl_pkg::KIND_END) |->
      token_first_i && token_last_i && !has_byte_i && last_i &&
      (error_code_i == jtl_pkg::ERR_NONE))
    else $error("malformed end-of-text item");

  a_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_byte_i && (error_code_i == jtl_pkg::ERR_NONE) |->
      data_byte_i == 8'd0)
    else $error("item without a byte carries data");

endmodule

bind json_token_lexer_unit jtl_checker u_jtl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .data_byte_i   (out_o.data_byte),
  .has_byte_i    (out_o.has_byte),
  .token_first_i (out_o.token_first),
  .token_last_i  (out_o.token_last),
  .error_code_i  (out_o.error_code),
  .last_i        (out_o.last)
);
